FILE: sv/rtab_pkg.sv
// Shared types and constants for the range to aligned blocks splitter.
package rtab_pkg;

    localparam int ADDR_W    = 32;
    localparam int LOG2_W    = 5;
    localparam int IDX_W     = 6;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;

    // One classified range as it sits in the queue between front and back
    typedef struct packed {
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic              is_empty;
    } rtab_range_t;

    // Back-end sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } rtab_state_t;

endpackage

FILE: sv/rtab_front.sv
// Front end: accepts range items, masks them to the address width and classifies empty ranges.
module rtab_front #(
    parameter int WIDTH = 32
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rtab_pkg::S_TDATA_W-1:0]    s_tdata,   // range_start[31:0], range_end[63:32]
    output logic                              push_valid,
    input  logic                              push_ready,
    output rtab_pkg::rtab_range_t             push_data
);
    import rtab_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << WIDTH) - 64'd1);

    logic [ADDR_W-1:0] start_m;
    logic [ADDR_W-1:0] end_m;

    // Drop address bits above WIDTH, then flag ranges that hold nothing
    always_comb begin
        start_m = s_tdata[ADDR_W-1:0] & ADDR_MASK;
        end_m   = s_tdata[2*ADDR_W-1:ADDR_W] & ADDR_MASK;
        push_data.range_start = start_m;
        push_data.range_end   = end_m;
        push_data.is_empty    = (start_m >= end_m);
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

FILE: sv/rtab_queue.sv
// Two-entry queue that decouples the classifier from the block generator.
module rtab_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rtab_pkg::rtab_range_t push_data,
    output logic                  pop_valid,
    input  logic                  pop,
    output rtab_pkg::rtab_range_t pop_data
);
    import rtab_pkg::*;

    rtab_range_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/rtab_back.sv
// Back end: walks one range, one aligned block per cycle into the free output register.
module rtab_back #(
    parameter int WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           pop_valid,
    output logic                           pop,
    input  rtab_pkg::rtab_range_t          pop_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rtab_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import rtab_pkg::*;

    localparam int KW = $clog2(WIDTH);

    rtab_state_t        st_reg, st_next;
    logic [WIDTH-1:0]   cur_reg, cur_next;
    logic [WIDTH-1:0]   span_reg, span_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  out_start_reg, out_start_next;
    logic [ADDR_W-1:0]  out_end_reg, out_end_next;
    logic [LOG2_W-1:0]  out_log2_reg, out_log2_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;

    logic               out_free;
    logic [KW-1:0]      tz_k;
    logic [KW-1:0]      msb_k;
    logic [KW-1:0]      blk_k;
    logic [WIDTH-1:0]   blk_size;
    logic [WIDTH-1:0]   blk_next;
    logic               blk_last;

    // Index of lowest set bit; a zero position counts as fully aligned
    function automatic logic [KW-1:0] low_one(input logic [WIDTH-1:0] v);
        logic [KW-1:0] r;
        r = KW'(WIDTH - 1);
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (v[i]) r = KW'(i);
        end
        return r;
    endfunction

    // Index of highest set bit
    function automatic logic [KW-1:0] high_one(input logic [WIDTH-1:0] v);
        logic [KW-1:0] r;
        r = '0;
        for (int i = 0; i < WIDTH; i++) begin
            if (v[i]) r = KW'(i);
        end
        return r;
    endfunction

    // Block size from alignment of the cursor and remaining span
    always_comb begin
        tz_k     = low_one(cur_reg);
        msb_k    = high_one(span_reg);
        blk_k    = (tz_k < msb_k) ? tz_k : msb_k;
        blk_size = {{(WIDTH-1){1'b0}}, 1'b1} << blk_k;
        blk_next = cur_reg + blk_size;
        blk_last = (blk_size == span_reg);
    end

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (pop_valid && out_free && !pop_data.is_empty) st_next = ST_RUN;
            end
            ST_RUN: begin
                if (out_free && blk_last) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        pop            = 1'b0;
        cur_next       = cur_reg;
        span_next      = span_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_log2_next  = out_log2_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (pop_valid && out_free) begin
                    pop = 1'b1;
                    if (pop_data.is_empty) begin
                        out_valid_next = 1'b1;
                        out_start_next = '0;
                        out_end_next   = '0;
                        out_log2_next  = '0;
                        out_idx_next   = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                    end else begin
                        cur_next  = pop_data.range_start[WIDTH-1:0];
                        span_next = pop_data.range_end[WIDTH-1:0]
                                  - pop_data.range_start[WIDTH-1:0];
                        idx_next  = '0;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_start_next = ADDR_W'(cur_reg);
                    out_end_next   = ADDR_W'(blk_next);
                    out_log2_next  = LOG2_W'(blk_k);
                    out_idx_next   = idx_reg;
                    out_last_next  = blk_last;
                    out_empty_next = 1'b0;
                    cur_next       = blk_next;
                    span_next      = span_reg - blk_size;
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        span_reg      <= span_next;
        idx_reg       <= idx_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_log2_reg  <= out_log2_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*ADDR_W - LOG2_W - IDX_W){1'b0}},
                       out_idx_reg, out_log2_reg, out_end_reg, out_start_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

endmodule

FILE: sv/range_to_aligned_blocks.sv
// Top level of the range to aligned power-of-two blocks splitter.
//
// Input channel s_*: one item is a half-open range [range_start, range_end).
// Output channel m_*: one item per naturally aligned block, ascending, with
// block start, end, log2 size and ordinal; m_tlast marks the final block of a
// range. A range with start >= end gives one item with m_tuser set and all
// block fields zero. Address bits at or above WIDTH are ignored.
// Ranges pass a classifier, then a two-entry queue, then the block generator.
// The generator first loads each range into its cursor and span registers,
// then emits one block per cycle while the output register is free; an empty
// range goes from the queue straight to the output register. The per-block
// step (lowest-set-bit and highest-set-bit encode, add and subtract on WIDTH
// bits) sets the cycle. A first block passes queue, range and output registers.
// Input is taken while the queue has room, even while a result waits.
// A stalled m_tready holds the output register and freezes the generator.
// Reset (aresetn low, synchronous) empties the queue and output register.
module range_to_aligned_blocks #(
    parameter int WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rtab_pkg::S_TDATA_W-1:0] s_tdata,   // range_start[31:0], range_end[63:32]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // block_start[31:0], block_end[63:32], block_log2[68:64], block_index[74:69], zeros
    output logic [rtab_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,   // last_block
    output logic                           m_tuser    // empty_range
);
    import rtab_pkg::*;

    logic        push_valid;
    logic        push_ready;
    rtab_range_t push_data;
    logic        pop_valid;
    logic        pop;
    rtab_range_t pop_data;

    rtab_front #(.WIDTH(WIDTH)) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rtab_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    rtab_back #(.WIDTH(WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: sv/rtab_checker.sv
// Port-level checks for the range splitter, bound to the top level.
module rtab_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rtab_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rtab_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);
    import rtab_pkg::*;

    // An offered input item holds steady until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed before acceptance");

    // A result item is never withdrawn while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // An empty-range item always closes its range
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("empty range item not marked last");

    // Block end minus start equals the block size
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
        ((m_tdata[63:32] - m_tdata[31:0]) == (32'd1 << m_tdata[68:64])))
        else $error("block size does not match log2 field");

    // Every block is naturally aligned
    a_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
        ((m_tdata[31:0] & ((32'd1 << m_tdata[68:64]) - 32'd1)) == 32'd0))
        else $error("block start not aligned to its size");

endmodule

bind range_to_aligned_blocks rtab_checker u_rtab_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the range to aligned power-of-two blocks splitter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtab_pkg::*;

    localparam int WIDTH      = 32;
    localparam int N_PROBES   = 18;
    localparam int N_RANDOM   = 152;
    localparam int N_TOTAL    = N_PROBES + N_RANDOM;
    localparam int QUIET_MAX  = 4000;
    localparam logic [63:0] ADDR_MASK = (64'd1 << WIDTH) - 64'd1;

    // One emitted block as seen on the result channel
    typedef struct packed {
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [LOG2_W-1:0] lg;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic              empty;
    } block_t;

    // Directed range; known=1 means the single block below is the answer
    typedef struct packed {
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] e;
        logic              known;
        block_t            blk;
    } probe_range_t;

    localparam probe_range_t PROBE_RANGES [N_PROBES] = '{
        // empty ranges: start >= end
        '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 5'd0, 6'd0, 1'b1, 1'b1}},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0, 32'h0, 5'd0, 6'd0, 1'b1, 1'b1}},
        '{32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0, 32'h0, 5'd0, 6'd0, 1'b1, 1'b1}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 5'd0, 6'd0, 1'b1, 1'b1}},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0, 32'h0, 5'd0, 6'd0, 1'b1, 1'b1}},
        // single aligned blocks of various sizes
        '{32'h0000_0000, 32'h0000_0001, 1'b1,
          '{32'h0000_0000, 32'h0000_0001, 5'd0, 6'd0, 1'b1, 1'b0}},
        '{32'h0000_0001, 32'h0000_0002, 1'b1,
          '{32'h0000_0001, 32'h0000_0002, 5'd0, 6'd0, 1'b1, 1'b0}},
        '{32'h0000_0003, 32'h0000_0004, 1'b1,
          '{32'h0000_0003, 32'h0000_0004, 5'd0, 6'd0, 1'b1, 1'b0}},
        '{32'h0000_0010, 32'h0000_0020, 1'b1,
          '{32'h0000_0010, 32'h0000_0020, 5'd4, 6'd0, 1'b1, 1'b0}},
        '{32'h8000_0000, 32'hC000_0000, 1'b1,
          '{32'h8000_0000, 32'hC000_0000, 5'd30, 6'd0, 1'b1, 1'b0}},
        '{32'h0000_0000, 32'h8000_0000, 1'b1,
          '{32'h0000_0000, 32'h8000_0000, 5'd31, 6'd0, 1'b1, 1'b0}},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 5'd0, 6'd0, 1'b1, 1'b0}},
        // multi-block ranges, checked by the predictor
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},  // zero start, widest span
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0},  // most blocks possible
        '{32'h0000_0007, 32'h0000_0009, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h8000_0001, 1'b0, '0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
    };

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    block_t blocks_due[$];
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     quiet_cycles   = 0;
    int     errors         = 0;
    int     ranges_sent    = 0;
    int     blocks_seen    = 0;
    int     empties_seen   = 0;

    range_to_aligned_blocks #(.WIDTH(WIDTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR %s: got %h want %h (block %0d)", what, got, want, blocks_seen);
        errors++;
    endtask

    // Append one expected block at the tail of the queue
    function automatic void expect_block(input block_t b);
        blocks_due.insert(blocks_due.size(), b);
    endfunction

    // Largest k with p aligned to 2^k (zero counts as fully aligned) and 2^k <= span
    function automatic int align_log2(input logic [63:0] p, input logic [63:0] span);
        int k;
        k = 0;
        while (k + 1 < WIDTH && (p & ((64'd1 << (k + 1)) - 64'd1)) == 64'd0
               && (64'd1 << (k + 1)) <= span)
            k++;
        return k;
    endfunction

    // Predict the block sequence for [s, e) and queue it
    function automatic void split_range(input logic [31:0] s, input logic [31:0] e);
        logic [63:0] pos;
        logic [63:0] lim;
        logic [63:0] nxt;
        int          k;
        int          n;
        block_t      b;
        pos = {32'd0, s} & ADDR_MASK;
        lim = {32'd0, e} & ADDR_MASK;
        if (pos >= lim) begin
            b = '{32'h0, 32'h0, 5'd0, 6'd0, 1'b1, 1'b1};
            expect_block(b);
            return;
        end
        n = 0;
        while (pos < lim && n < 64) begin
            k       = align_log2(pos, lim - pos);
            nxt     = pos + (64'd1 << k);
            b.lo    = pos[31:0];
            b.hi    = nxt[31:0];
            b.lg    = k[4:0];
            b.idx   = n[5:0];
            b.last  = (nxt >= lim);
            b.empty = 1'b0;
            expect_block(b);
            pos = nxt;
            n++;
        end
    endfunction

    // Random range: mostly well-formed with varied spans, some empty and noise
    task automatic draw_range(output logic [31:0] s, output logic [31:0] e);
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] base;
        int          c;
        int          k;
        a = $urandom;
        b = $urandom;
        c = $urandom_range(0, 99);
        if (c < 12) begin
            s = (a >= b) ? a : b;
            e = (a >= b) ? b : a;
        end else if (c < 40) begin
            s = (a < b) ? a : b;
            e = (a < b) ? b : a;
        end else if (c < 70) begin
            s = a;
            e = a + $urandom_range(1, 300);
        end else if (c < 90) begin
            k    = $urandom_range(0, 31);
            base = {32'd0, a} & ~((64'd1 << k) - 64'd1);
            s    = base[31:0];
            e    = s + (32'd1 << k) + $urandom_range(0, 3);
        end else begin
            s = a;
            e = b;
        end
    endtask

    // Present one range, idling first at the current rate, and wait for acceptance
    task automatic offer_range(input logic [31:0] s, input logic [31:0] e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {e, s};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker and activity counter
    always @(posedge aclk) begin
        block_t got;
        block_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[68:64], m_tdata[74:69],
                        m_tlast, m_tuser};
                if (blocks_due.size() == 0) begin
                    report("block with no range pending", got.lo, 32'h0);
                end else begin
                    want = blocks_due.pop_front();
                    if (got.lo !== want.lo)
                        report("block_start", got.lo, want.lo);
                    if (got.hi !== want.hi)
                        report("block_end", got.hi, want.hi);
                    if (got.lg !== want.lg)
                        report("block_log2", 32'(got.lg), 32'(want.lg));
                    if (got.idx !== want.idx)
                        report("block_index", 32'(got.idx), 32'(want.idx));
                    if (got.last !== want.last)
                        report("last_block", 32'(got.last), 32'(want.last));
                    if (got.empty !== want.empty)
                        report("empty_range", 32'(got.empty), 32'(want.empty));
                end
                blocks_seen++;
                if (m_tuser === 1'b1)
                    empties_seen++;
            end
        end
    end

    // Watchdog: too long with no item moving on either side
    initial begin
        while (quiet_cycles < QUIET_MAX)
            @(posedge aclk);
        $display("ERROR watchdog: %0d cycles without progress", QUIET_MAX);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus
    initial begin
        int          i;
        int          phase;
        logic [31:0] s;
        logic [31:0] e;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < N_TOTAL; i++) begin
            // no idling, sender idle, receiver stalling, both
            phase = (i * 4) / N_TOTAL;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (i < N_PROBES) begin
                s = PROBE_RANGES[i].s;
                e = PROBE_RANGES[i].e;
            end else begin
                draw_range(s, e);
            end
            offer_range(s, e);
            ranges_sent++;
            if (i < N_PROBES && PROBE_RANGES[i].known)
                expect_block(PROBE_RANGES[i].blk);
            else
                split_range(s, e);
        end
        s_tvalid <= 1'b0;

        // drain, then give the block time to show any stray output
        recv_stall_pct = 0;
        while (blocks_due.size() != 0)
            @(posedge aclk);
        repeat (2 * WIDTH + 8) @(posedge aclk);
        if (blocks_due.size() != 0)
            report("blocks never delivered", 32'h0, 32'(blocks_due.size()));

        $display("covered %0d ranges (%0d directed, %0d random) giving %0d blocks, %0d empty",
                 ranges_sent, N_PROBES, N_RANDOM, blocks_seen, empties_seen);
        $display("phases: free running, sender gaps, receiver stalls, both mixed");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: range_to_aligned_blocks.f
sv/rtab_pkg.sv
sv/rtab_front.sv
sv/rtab_queue.sv
sv/rtab_back.sv
sv/range_to_aligned_blocks.sv
sv/rtab_checker.sv
tb/tb.sv
